FILE: rtl/core/pcrc_pkg.sv
// Shared constants, types and the byte-wise CRC-32 update for the PNG CRC repair core.
package pcrc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       replaced;
    logic       repair_stopped;
  } result_t;

  // Reflected CRC-32, one byte, eight shift/xor steps.
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pcrc_parser.sv
// Chunk parser: parse state, CRC accumulation and the per-byte result.
module pcrc_parser #(
  parameter int SIGNATURE_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              start_of_file,
  input  logic [31:0]       file_length,
  output pcrc_pkg::result_t res
);
  import pcrc_pkg::*;

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;
  localparam logic [2:0] PH_IDLE = 3'd5;

  localparam logic [31:0] SIG_LEN = 32'(SIGNATURE_BYTES);

  logic [31:0] byte_position, byte_position_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [2:0]  field_byte_count, field_byte_count_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [31:0] running_crc, running_crc_next;
  logic        stopped_flag, stopped_flag_next;

  // state seen by this byte (start_of_file clears first)
  logic [31:0] pos;
  logic [2:0]  ph;
  logic [2:0]  cnt;
  logic [31:0] len;
  logic [31:0] rem;
  logic [31:0] crc;
  logic        stp;

  logic [31:0] len_new;
  logic [31:0] rem_dec;
  logic [31:0] crc_upd;
  logic [31:0] crc_fin;
  logic [33:0] chunk_end;
  logic [7:0]  ob;
  logic        rep;

  always_comb begin
    if (start_of_file) begin
      pos = '0;
      ph  = PH_SIG;
      cnt = '0;
      len = '0;
      rem = '0;
      crc = CRC_ONES;
      stp = 1'b0;
    end else begin
      pos = byte_position;
      ph  = parse_phase;
      cnt = field_byte_count;
      len = chunk_length;
      rem = data_remaining;
      crc = running_crc;
      stp = stopped_flag;
    end
    if (ph == PH_SIG && pos >= SIG_LEN) begin
      ph = PH_LEN;
    end
  end

  assign len_new   = (cnt == 3'd0) ? {24'd0, data_byte} : {len[23:0], data_byte};
  assign rem_dec   = (rem != 32'd0) ? rem - 32'd1 : rem;
  assign crc_upd   = crc32_byte(crc, data_byte);
  assign crc_fin   = ~crc;
  // 64-bit sum in the spec; 34 bits cannot wrap here
  assign chunk_end = {2'b00, pos} + 34'd9 + {2'b00, len_new};

  always_comb begin
    parse_phase_next      = ph;
    field_byte_count_next = cnt;
    chunk_length_next     = len;
    data_remaining_next   = rem;
    running_crc_next      = crc;
    stopped_flag_next     = stp;
    ob                    = data_byte;
    rep                   = 1'b0;
    unique case (ph)
      PH_LEN: begin
        if (cnt == 3'd0 && pos >= file_length) begin
          parse_phase_next = PH_IDLE;
        end else if (cnt == 3'd0 && (file_length - pos) < 32'd4) begin
          stopped_flag_next = 1'b1;
          parse_phase_next  = PH_IDLE;
        end else begin
          chunk_length_next     = len_new;
          field_byte_count_next = cnt + 3'd1;
          if (cnt >= 3'd3) begin
            field_byte_count_next = '0;
            if (chunk_end > {2'b00, file_length}) begin
              stopped_flag_next = 1'b1;
              parse_phase_next  = PH_IDLE;
            end else begin
              running_crc_next = CRC_ONES;
              parse_phase_next = PH_TYPE;
            end
          end
        end
      end
      PH_TYPE: begin
        running_crc_next      = crc_upd;
        field_byte_count_next = cnt + 3'd1;
        if (cnt >= 3'd3) begin
          field_byte_count_next = '0;
          data_remaining_next   = len;
          parse_phase_next      = (len == 32'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        running_crc_next    = crc_upd;
        data_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          parse_phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        rep = 1'b1;
        unique case (cnt[1:0])
          2'd0:    ob = crc_fin[31:24];
          2'd1:    ob = crc_fin[23:16];
          2'd2:    ob = crc_fin[15:8];
          default: ob = crc_fin[7:0];
        endcase
        field_byte_count_next = cnt + 3'd1;
        if (cnt >= 3'd3) begin
          field_byte_count_next = '0;
          running_crc_next      = CRC_ONES;
          parse_phase_next      = PH_LEN;
        end
      end
      default: begin
      end
    endcase
    byte_position_next = (pos != POS_MAX) ? pos + 32'd1 : pos;
  end

  assign res.out_byte       = ob;
  assign res.replaced       = rep;
  assign res.repair_stopped = stopped_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      parse_phase      <= PH_SIG;
      field_byte_count <= '0;
      chunk_length     <= '0;
      data_remaining   <= '0;
      running_crc      <= CRC_ONES;
      stopped_flag     <= 1'b0;
    end else if (step) begin
      byte_position    <= byte_position_next;
      parse_phase      <= parse_phase_next;
      field_byte_count <= field_byte_count_next;
      chunk_length     <= chunk_length_next;
      data_remaining   <= data_remaining_next;
      running_crc      <= running_crc_next;
      stopped_flag     <= stopped_flag_next;
    end
  end

endmodule

FILE: rtl/core/pcrc_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
module pcrc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pcrc_pkg::result_t res_in,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              ready,
  output pcrc_pkg::result_t res_out
);
  import pcrc_pkg::*;

  logic    vld, vld_next;
  result_t res_q;

  assign ready = !vld || !out_stall;

  always_comb begin
    if (load) begin
      vld_next = 1'b1;
    end else if (!out_stall) begin
      vld_next = 1'b0;
    end else begin
      vld_next = vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

  assign out_valid = vld;
  assign res_out   = res_q;

endmodule

FILE: rtl/core/png_chunk_crc_repair_core.sv
// Top level of the PNG chunk CRC repair core: input register, parser and result register.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     data_byte, start_of_file
//   output    out        out_valid / out_stall   out_byte, replaced, repair_stopped
//   config    in         file_length_wr          file_length
//
// One byte per cycle sustained while out_stall is low; each byte passes the input
// register, then the parser into the result register, before it can be transferred.
// The CRC update of a byte is one 8-step shift/xor function on the running CRC.
// rst is synchronous: parse state cleared, file_length set to zero.
// A stalled result holds; the input register fills behind it and then
// in_stall goes high until the result is transferred.
module png_chunk_crc_repair_core #(
  parameter int SIGNATURE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  input  logic        file_length_wr,
  input  logic [31:0] file_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        replaced,
  output logic        repair_stopped
);
  import pcrc_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_sof;
  logic [31:0] file_length_q;
  logic        out_ready;
  logic        step;
  logic        in_xfer;
  result_t     res_comb;
  result_t     res_q;

  assign step     = s1_valid && out_ready;
  assign in_stall = s1_valid && !out_ready;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte <= data_byte;
      s1_sof  <= start_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length_q <= '0;
    end else if (file_length_wr) begin
      file_length_q <= file_length;
    end
  end

  pcrc_parser #(
    .SIGNATURE_BYTES(SIGNATURE_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (s1_byte),
    .start_of_file(s1_sof),
    .file_length  (file_length_q),
    .res          (res_comb)
  );

  pcrc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res_in   (res_comb),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .ready    (out_ready),
    .res_out  (res_q)
  );

  assign out_byte       = res_q.out_byte;
  assign replaced       = res_q.replaced;
  assign repair_stopped = res_q.repair_stopped;

  // a rewritten CRC byte only comes while repair is still running
  a_rep_not_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && replaced |-> !repair_stopped)
    else $error("CRC byte replaced after repair stopped");

  // input register only pushes back while it holds a byte
  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stall with empty input register");

  // a held byte is not lost or changed while the result side is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_ready |=> s1_valid && $stable(s1_byte) && $stable(s1_sof))
    else $error("input register changed while blocked");

  // the parser never advances into an occupied, stalled result register
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !step)
    else $error("result overwritten while stalled");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the PNG chunk CRC repair core: byte-stream predictor and scoreboard.
module tb;

  localparam int SIG_BYTES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_BYTES = 1050;
  localparam int HOLD_CYCLES = 60;

  typedef enum logic [2:0] {
    SIGNATURE,
    LENGTH_FIELD,
    TYPE_FIELD,
    DATA_FIELD,
    CRC_FIELD,
    PASS_THROUGH
  } parse_phase_e;

  class crc_fixup_scoreboard;
    logic [31:0]  file_len;
    logic [31:0]  position;
    parse_phase_e phase;
    logic [2:0]   field_count;
    logic [31:0]  chunk_len;
    logic [31:0]  data_left;
    logic [31:0]  crc_acc;
    logic         stopped;
    pcrc_pkg::result_t expected_bytes[$];
    int mismatches;
    int checked;

    function new();
      file_len = '0;
      mismatches = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      position = '0;
      phase = SIGNATURE;
      field_count = '0;
      chunk_len = '0;
      data_left = '0;
      crc_acc = pcrc_pkg::CRC_ONES;
      stopped = 1'b0;
    endfunction

    function void set_file_length(logic [31:0] v);
      file_len = v;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
      logic [31:0] v;
      logic lsb;
      v = acc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
        lsb = v[0];
        v = v >> 1;
        if (lsb) v = v ^ pcrc_pkg::CRC_POLY;
      end
      return v;
    endfunction

    // Advance the parser by one accepted byte and queue the byte it should emit.
    function void take_byte(logic [7:0] b, logic sof);
      logic [7:0]  ob;
      logic        rep;
      logic [31:0] fin;
      pcrc_pkg::result_t r;
      ob = b;
      rep = 1'b0;
      if (sof) restart();
      if (phase == SIGNATURE && position >= SIG_BYTES) phase = LENGTH_FIELD;
      case (phase)
        LENGTH_FIELD: begin
          if (field_count == 0 && position >= file_len) begin
            phase = PASS_THROUGH;
          end else if (field_count == 0 && file_len - position < 4) begin
            // length field would run past end of file
            stopped = 1'b1;
            phase = PASS_THROUGH;
          end else begin
            chunk_len = (field_count == 0) ? {24'd0, b} : {chunk_len[23:0], b};
            field_count = field_count + 3'd1;
            if (field_count == 4) begin
              field_count = '0;
              // 64-bit sum: a huge length must not wrap into a fit
              if ({32'd0, position} + 64'd9 + {32'd0, chunk_len} > {32'd0, file_len}) begin
                stopped = 1'b1;
                phase = PASS_THROUGH;
              end else begin
                crc_acc = pcrc_pkg::CRC_ONES;
                phase = TYPE_FIELD;
              end
            end
          end
        end
        TYPE_FIELD: begin
          crc_acc = crc_step(crc_acc, b);
          field_count = field_count + 3'd1;
          if (field_count == 4) begin
            field_count = '0;
            data_left = chunk_len;
            phase = (chunk_len == 0) ? CRC_FIELD : DATA_FIELD;
          end
        end
        DATA_FIELD: begin
          crc_acc = crc_step(crc_acc, b);
          if (data_left != 0) data_left = data_left - 1;
          if (data_left == 0) phase = CRC_FIELD;
        end
        CRC_FIELD: begin
          fin = ~crc_acc >> (6'd24 - {1'b0, field_count[1:0], 3'b000});
          ob = fin[7:0];
          rep = 1'b1;
          field_count = field_count + 3'd1;
          if (field_count == 4) begin
            field_count = '0;
            crc_acc = pcrc_pkg::CRC_ONES;
            phase = LENGTH_FIELD;
          end
        end
        default: ;
      endcase
      if (position != pcrc_pkg::POS_MAX) position = position + 1;
      r.out_byte = ob;
      r.replaced = rep;
      r.repair_stopped = stopped;
      expected_bytes.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("mismatch at result %0d: %s", checked, msg);
      mismatches++;
    endtask

    task check_byte(logic [7:0] ob, logic rep, logic stp);
      pcrc_pkg::result_t want;
      if (expected_bytes.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      want = expected_bytes.pop_front();
      if (ob !== want.out_byte)
        report($sformatf("out_byte %h, expected %h", ob, want.out_byte));
      if (rep !== want.replaced)
        report($sformatf("replaced %b, expected %b", rep, want.replaced));
      if (stp !== want.repair_stopped)
        report($sformatf("repair_stopped %b, expected %b", stp, want.repair_stopped));
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        start_of_file;
  logic        flen_wr;
  logic [31:0] flen_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        replaced;
  logic        repair_stopped;

  crc_fixup_scoreboard board = new();

  logic [7:0] file_q[$];
  int  sent;
  int  cycles;
  int  hold_left;
  bit  calm;
  bit  hold_req;
  bit  hold_done;

  png_chunk_crc_repair_core #(.SIGNATURE_BYTES(SIG_BYTES)) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .start_of_file  (start_of_file),
    .file_length_wr (flen_wr),
    .file_length    (flen_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .replaced       (replaced),
    .repair_stopped (repair_stopped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: check transfers at the rising edge, drive stall at the falling edge.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_byte(out_byte, replaced, repair_stopped);
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 23);
      end
    end
  end

  task send_byte(input logic [7:0] b, input logic sof);
    while (!calm && $urandom_range(0, 99) < 23) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    start_of_file <= sof;
    do @(posedge clk); while (in_stall);
    board.take_byte(b, sof);
    sent++;
  endtask

  // Register write only with the core drained.
  task set_file_length(input logic [31:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    flen_wr <= 1'b1;
    flen_data <= v;
    board.set_file_length(v);
    @(negedge clk);
    flen_wr <= 1'b0;
  endtask

  task send_file(input logic [31:0] flen, input bit noisy, input bit long_hold);
    set_file_length(flen);
    if (long_hold) hold_req = 1'b1;
    foreach (file_q[i])
      send_byte(file_q[i], (i == 0) || (noisy && $urandom_range(0, 7) == 0));
    file_q.delete();
  endtask

  task add_signature();
    if ($urandom_range(0, 1))
      file_q = {file_q, 8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    else
      repeat (SIG_BYTES) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task add_chunk(input logic [31:0] len_field, input int body);
    for (int k = 3; k >= 0; k--) file_q.push_back(len_field[8*k +: 8]);
    repeat (4 + body + 4) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task build_png(input int chunks, input int max_len);
    int len;
    add_signature();
    repeat (chunks) begin
      len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_len);
      add_chunk(len, len);
    end
  endtask

  initial begin
    int kind;
    int sz;
    logic [31:0] flen;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    start_of_file = 1'b0;
    flen_wr = 1'b0;
    flen_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    sent = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // empty file: chunk parsing ends at once
    file_q = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A, 8'h00};
    send_file(32'd0, 1'b0, 1'b0);
    // zero-length chunk, then an all-ones length that cannot fit even the largest file
    add_signature();
    add_chunk(32'd0, 0);
    file_q = {file_q, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A};
    send_file(32'hFFFF_FFFF, 1'b0, 1'b0);

    while (sent < TARGET_BYTES) begin
      calm = (sent >= 350 && sent < 550);
      kind = $urandom_range(0, 99);
      if (!hold_done && sent >= 650) begin
        // long receiver hold while the sender keeps offering
        build_png(1, 1);
        file_q.delete();
        add_signature();
        add_chunk(32'd80, 80);
        hold_done = 1'b1;
        send_file(file_q.size(), 1'b0, 1'b1);
      end else if (kind < 60) begin
        build_png($urandom_range(1, 4), ($urandom_range(0, 4) == 0) ? 40 : 12);
        flen = file_q.size();
        if ($urandom_range(0, 99) < 30)
          repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom_range(0, 255)));
        send_file(flen, 1'b0, 1'b0);
      end else if (kind < 70) begin
        // file shorter than its chunks
        build_png($urandom_range(1, 3), 12);
        send_file($urandom_range(0, file_q.size() - 1), 1'b0, 1'b0);
      end else if (kind < 78) begin
        // fewer than four bytes left for the next length field
        build_png($urandom_range(1, 3), 12);
        flen = file_q.size() + $urandom_range(1, 3);
        repeat ($urandom_range(1, 5)) file_q.push_back(8'($urandom_range(0, 255)));
        send_file(flen, 1'b0, 1'b0);
      end else if (kind < 86) begin
        // next file starts in the middle of this one
        build_png($urandom_range(1, 3), 12);
        flen = file_q.size() + $urandom_range(1, 500);
        sz = $urandom_range(1, 6);
        repeat (sz) void'(file_q.pop_back());
        send_file(flen, 1'b0, 1'b0);
      end else if (kind < 93) begin
        repeat ($urandom_range(5, 30)) file_q.push_back(8'($urandom_range(0, 255)));
        flen = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);
        send_file(flen, 1'b1, 1'b0);
      end else begin
        add_signature();
        add_chunk($urandom, $urandom_range(0, 6));
        flen = $urandom_range(0, 1) ? $urandom : file_q.size() + $urandom_range(0, 64);
        send_file(flen, 1'b0, 1'b0);
      end
    end

    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.pending() != 0) board.report("expected results left over");
    if (board.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
